// File: rtl/spm_pkg.sv
package spm_pkg;

  localparam int unsigned PAGE_BYTES_DEF   = 4096;
  localparam int unsigned HEADER_BYTES_DEF = 4;
  localparam int unsigned SLOT_BYTES_DEF   = 4;
  localparam int unsigned MAX_SLOTS_DEF    = 512;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned SLOT_W = 9;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned OFF_W  = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PAGE_W = 16;
  localparam int unsigned ST_W   = 3;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam cmd_t CMD_INSERT  = 3'd0;
  localparam cmd_t CMD_WRITE   = 3'd1;
  localparam cmd_t CMD_DELETE  = 3'd2;
  localparam cmd_t CMD_RESTORE = 3'd3;
  localparam cmd_t CMD_READ    = 3'd4;
  localparam cmd_t CMD_QUERY   = 3'd5;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_NOSPACE = 3'd1;
  localparam status_t ST_BADSLOT = 3'd2;
  localparam status_t ST_DELETED = 3'd3;
  localparam status_t ST_NOTDEL  = 3'd4;
  localparam status_t ST_RANGE   = 3'd5;

endpackage

// File: rtl/slotted_page_manager.sv
// Commands finish in S_EVAL; a read byte that passes its checks finishes in S_READ.
// One command at a time: busy stays high and no start is accepted while
//   the slot table read, the evaluation and any page store read are in flight.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset (rst, synchronous): slot count 0, free pointer at the page size, page number 0;
//   slot table and page store contents are undefined until written. No clearing pass.
module slotted_page_manager #(
  parameter int unsigned PAGE_BYTES   = spm_pkg::PAGE_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = spm_pkg::HEADER_BYTES_DEF,
  parameter int unsigned SLOT_BYTES   = spm_pkg::SLOT_BYTES_DEF,
  parameter int unsigned MAX_SLOTS    = spm_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [spm_pkg::CMD_W-1:0]    command,
  input  logic [spm_pkg::SLOT_W-1:0]   slot_index,
  input  logic [spm_pkg::LEN_W-1:0]    tuple_length,
  input  logic [spm_pkg::OFF_W-1:0]    tuple_offset,
  input  logic [spm_pkg::OFF_W-1:0]    byte_index,
  input  logic [spm_pkg::BYTE_W-1:0]   data_byte,
  output logic                         done,
  output logic [spm_pkg::ST_W-1:0]     status,
  output logic [spm_pkg::SLOT_W-1:0]   slot_assigned,
  output logic [spm_pkg::BYTE_W-1:0]   data_out,
  output logic                         slot_valid,
  output logic [spm_pkg::OFF_W-1:0]    tuple_offset_out,
  output logic [spm_pkg::LEN_W-1:0]    tuple_length_out,
  output logic [spm_pkg::PAGE_W-1:0]   record_page,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spm_pkg::PAGE_W-1:0]   cfg_data
);
  import spm_pkg::*;

  localparam int unsigned FT_W    = $clog2(PAGE_BYTES + 1);
  localparam int unsigned EOFF_W  = (FT_W > OFF_W) ? FT_W : OFF_W;
  localparam int unsigned SUM_W   = EOFF_W + 1;
  localparam int unsigned PAGE_AW = $clog2(PAGE_BYTES);
  localparam int unsigned CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int unsigned SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CMP_W   = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int unsigned NEED_W  =
    $clog2(HEADER_BYTES + MAX_SLOTS * SLOT_BYTES + PAGE_BYTES + 8192 + SLOT_BYTES);
  localparam int unsigned ENT_W   = EOFF_W + LEN_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state, state_next;

  logic [ENT_W-1:0] slot_mem [MAX_SLOTS];
  logic [BYTE_W-1:0] page_mem [PAGE_BYTES];

  logic [ENT_W-1:0]   entry_q;
  logic [BYTE_W-1:0]  pg_q;
  cmd_t               cmd_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [LEN_W-1:0]   len_q;
  logic [OFF_W-1:0]   off_q;
  logic [OFF_W-1:0]   bi_q;
  logic [BYTE_W-1:0]  db_q;
  logic [EOFF_W-1:0]  rd_off;
  logic [LEN_W-1:0]   rd_len;

  logic [CNT_W-1:0]   slot_total, slot_total_next;
  logic [FT_W-1:0]    free_top, free_top_next;
  logic [PAGE_W-1:0]  page_number;

  logic               accept;
  logic [EOFF_W-1:0]  ent_off;
  logic [LEN_W-1:0]   ent_len;
  logic               absent, deleted, range_bad, no_space;
  logic [SUM_W-1:0]   byte_sum;
  logic [NEED_W-1:0]  need_end;
  logic [FT_W-1:0]    carved;

  logic               tbl_we, pg_we, pg_re, fin;
  logic [SLOT_AW-1:0] tbl_wa;
  logic [ENT_W-1:0]   tbl_wd;
  logic [PAGE_AW-1:0] pg_addr;
  status_t            st_c;
  logic [SLOT_W-1:0]  asg_c;
  logic               valid_c;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign ent_off   = entry_q[ENT_W-1:LEN_W];
  assign ent_len   = entry_q[LEN_W-1:0];
  assign absent    = CMP_W'(slot_q) >= CMP_W'(slot_total);
  assign deleted   = (ent_off == '0) && (ent_len == '0);
  assign byte_sum  = SUM_W'(ent_off) + SUM_W'(bi_q);
  assign range_bad = (LEN_W'(bi_q) >= ent_len) || (32'(byte_sum) >= PAGE_BYTES);
  assign need_end  = NEED_W'(HEADER_BYTES) + NEED_W'(slot_total) * NEED_W'(SLOT_BYTES)
                   + NEED_W'(len_q) + NEED_W'(SLOT_BYTES);
  assign no_space  = (32'(slot_total) >= MAX_SLOTS) || (need_end > NEED_W'(free_top));
  assign carved    = free_top - FT_W'(len_q);
  assign pg_addr   = PAGE_AW'(byte_sum);

  always_comb begin
    state_next      = state;
    slot_total_next = slot_total;
    free_top_next   = free_top;
    tbl_we          = 1'b0;
    tbl_wa          = SLOT_AW'(slot_q);
    tbl_wd          = '0;
    pg_we           = 1'b0;
    pg_re           = 1'b0;
    fin             = 1'b0;
    st_c            = ST_OK;
    asg_c           = '0;
    valid_c         = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        fin        = 1'b1;
        state_next = S_IDLE;
        case (cmd_q)
          CMD_INSERT: begin
            if (no_space) begin
              st_c = ST_NOSPACE;
            end else begin
              tbl_we          = 1'b1;
              tbl_wa          = SLOT_AW'(slot_total);
              tbl_wd          = {EOFF_W'(carved), len_q};
              free_top_next   = carved;
              slot_total_next = slot_total + 1'b1;
              asg_c           = SLOT_W'(slot_total);
            end
          end
          CMD_WRITE, CMD_READ: begin
            if (absent) begin
              st_c = ST_BADSLOT;
            end else if (deleted) begin
              st_c = ST_DELETED;
            end else if (range_bad) begin
              st_c = ST_RANGE;
            end else if (cmd_q == CMD_WRITE) begin
              pg_we = 1'b1;
            end else begin
              pg_re      = 1'b1;
              fin        = 1'b0;
              state_next = S_READ;
            end
          end
          CMD_DELETE: begin
            if (absent) begin
              st_c = ST_BADSLOT;
            end else if (deleted) begin
              st_c = ST_DELETED;
            end else begin
              tbl_we = 1'b1;
            end
          end
          CMD_RESTORE: begin
            if (absent) begin
              st_c = ST_BADSLOT;
            end else if (!deleted) begin
              st_c = ST_NOTDEL;
            end else begin
              tbl_we = 1'b1;
              tbl_wd = {EOFF_W'(off_q), len_q};
            end
          end
          CMD_QUERY: begin
            valid_c = !absent && (ent_len != '0);
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_q <= slot_mem[SLOT_AW'(slot_index)];
    end
    if (tbl_we) begin
      slot_mem[tbl_wa] <= tbl_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (pg_re) begin
      pg_q <= page_mem[pg_addr];
    end
    if (pg_we) begin
      page_mem[pg_addr] <= db_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= command;
      slot_q <= slot_index;
      len_q  <= tuple_length;
      off_q  <= tuple_offset;
      bi_q   <= byte_index;
      db_q   <= data_byte;
    end
    if (pg_re) begin
      rd_off <= ent_off;
      rd_len <= ent_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_total  <= '0;
      free_top    <= FT_W'(PAGE_BYTES);
      page_number <= '0;
      done        <= 1'b0;
    end else begin
      state      <= state_next;
      slot_total <= slot_total_next;
      free_top   <= free_top_next;
      done       <= fin || (state == S_READ);
      if (cfg_valid && cfg_ready) begin
        page_number <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      status           <= st_c;
      slot_assigned    <= asg_c;
      data_out         <= '0;
      slot_valid       <= valid_c;
      tuple_offset_out <= '0;
      tuple_length_out <= '0;
      record_page      <= '0;
    end else if (state == S_READ) begin
      status           <= ST_OK;
      slot_assigned    <= '0;
      data_out         <= pg_q;
      slot_valid       <= 1'b0;
      tuple_offset_out <= OFF_W'(rd_off);
      tuple_length_out <= rd_len;
      record_page      <= page_number;
    end
  end

  a_done_follows_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_EVAL || $past(state) == S_READ))
    else $error("done without an item in flight");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EVAL))
    else $error("accepted item not evaluated");

  a_slot_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(slot_total) <= MAX_SLOTS)
    else $error("slot count beyond limit");

  a_free_top_bound: assert property (@(posedge clk) disable iff (rst)
    32'(free_top) <= PAGE_BYTES)
    else $error("free pointer beyond page");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && cmd_q == CMD_INSERT && !no_space)
      |=> (slot_total == $past(slot_total) + 1'b1))
    else $error("insert did not advance slot count");

endmodule
